// ----- design/grwd_pkg.sv -----
// Package for the grid ray wall-distance block: sequencer states and
// fixed-point constants shared by the top level and the square-root unit.
// No dependencies.
`timescale 1ns / 1ps
package grwd_pkg;

   localparam int COORD_W   = 48;   // walk coordinate, Q.18 signed
   localparam int TILE_SH   = 18;   // one tile = 2^18 LSB
   localparam int DIM_W     = 10;   // map dimension compare width
   localparam int DIST_W    = 25;
   localparam int SQ_IN_W   = 52;   // square-root radicand
   localparam int SQ_ROOT_W = 26;
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   localparam logic [15:0] ANG_QUARTER  = 16'd16384;
   localparam logic [15:0] ANG_HALF     = 16'd32768;
   localparam logic [15:0] ANG_3QUARTER = 16'd49152;

   localparam logic CSR_MAP_WIDTH  = 1'b0;
   localparam logic CSR_MAP_HEIGHT = 1'b1;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CAST  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MUL,
      ST_POS,
      ST_ADDR,
      ST_CHECK,
      ST_DIST,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_SUM,
      ST_ROOT,
      ST_OUT
   } state_type;

endpackage

// ----- design/grwd_map.sv -----
// One-bit wall map memory with a clearing sweep after reset.
// Uses grwd_pkg (no items needed beyond the house import).
`timescale 1ns / 1ps
module grwd_map
   import grwd_pkg::*;
#(
   parameter int MAP_COLS = 64,
   parameter int MAP_ROWS = 64,
   parameter int AW = 12
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_data,
   output logic          clearing
);
   localparam int DEPTH = MAP_COLS * MAP_ROWS;

   logic          mem [DEPTH];
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic          clr_busy_ff, clr_busy_in;
   logic          rd_data_ff;
   logic          we;
   logic [AW-1:0] waddr;
   logic          wdata;

   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + AW'(1);
         if (clr_cnt_ff == AW'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   assign we    = clr_busy_ff | wr_en;
   assign waddr = clr_busy_ff ? clr_cnt_ff : wr_addr;
   assign wdata = clr_busy_ff ? 1'b0 : wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_cnt_ff  <= clr_cnt_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clr_busy_ff;

endmodule

// ----- design/grwd_sqrt.sv -----
// Bit-serial integer square root, one root bit per cycle.
// Uses grwd_pkg for operand widths.
`timescale 1ns / 1ps
module grwd_sqrt
   import grwd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SQ_IN_W-1:0]   value,
   output logic                 done,
   output logic [SQ_ROOT_W-1:0] root
);
   localparam int REM_W = SQ_ROOT_W + 3;

   logic [SQ_IN_W-1:0]   val_ff, val_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [SQ_ROOT_W-1:0] root_ff, root_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [REM_W-1:0]     rem_sh;
   logic [REM_W-1:0]     trial;

   always_comb begin
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[REM_W-3:0], val_ff[SQ_IN_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      if (start) begin
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in = {val_ff[SQ_IN_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[SQ_ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[SQ_ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(SQ_ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ----- design/grid_ray_wall_distance.sv -----
// Grid ray caster top level: sequencer, shared multiplier and walk datapath.
// Depends on grwd_pkg, grwd_map and grwd_sqrt.
`timescale 1ns / 1ps
// Usage:
//  req_* channel: one transaction is a map write (req_tuser = 0) or a ray
//    cast (req_tuser = 1). A write gives no result.
//  rsp_* channel: one transaction per cast with hit flag and distance for
//    the horizontal-line and the vertical-line walk.
//  csr_* port: map_width (index 0) and map_height (index 1); write only
//    while idle.
//  Walk: each walk does the setup multiply, then per visited crossing one map
//    read and one check and step; a hit adds two squares and the bit-serial
//    root. The map read loop sets the worst case per cast.
//  One cast is in flight at a time; req_tready is low while it runs.
//  Reset: the wall map is cleared by a sweep over all MAP_COLS * MAP_ROWS
//    cells (4096 by default), during which req_tready stays low; csr writes are
//    taken meanwhile. Registers return to 64 x 64.
//  Stall: the result holds on rsp_tdata until rsp_tready; no new request is
//    taken until then.
module grid_ray_wall_distance
   import grwd_pkg::*;
#(
   parameter int MAP_COLS  = 64,
   parameter int MAP_ROWS  = 64,
   parameter int MAX_STEPS = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // cell_col[5:0], cell_row[11:6], cell_is_wall[12], player_x[36:13],
   // player_y[60:37], angle[76:61], inv_tan_neg[108:77], tan_neg[140:109]
   input  logic [143:0] req_tdata,
   // opcode[0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // hit_h[0], dist_h[25:1], hit_v[26], dist_v[51:27]
   output logic [55:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [6:0]   csr_wdata
);
   localparam int AW = (MAP_COLS * MAP_ROWS > 1) ? $clog2(MAP_COLS * MAP_ROWS) : 1;
   localparam int STEP_W = $clog2(MAX_STEPS + 1);
   localparam logic [COORD_W-1:0] TILE = COORD_W'(1) << TILE_SH;

   // request fields
   logic [5:0]  f_col, f_row;
   logic        f_wall;
   logic [23:0] f_px, f_py;
   logic [15:0] f_ang;
   logic [31:0] f_at, f_nt;

   assign f_col  = req_tdata[5:0];
   assign f_row  = req_tdata[11:6];
   assign f_wall = req_tdata[12];
   assign f_px   = req_tdata[36:13];
   assign f_py   = req_tdata[60:37];
   assign f_ang  = req_tdata[76:61];
   assign f_at   = req_tdata[108:77];
   assign f_nt   = req_tdata[140:109];

   state_type state_ff, state_in;

   logic [6:0]  map_width_ff, map_height_ff;
   logic [23:0] px_ff, px_in, py_ff, py_in;
   logic [15:0] ang_ff, ang_in;
   logic [31:0] at_ff, at_in, nt_ff, nt_in;
   logic [COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in, sx_ff, sx_in, sy_ff, sy_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic        walk_v_ff, walk_v_in;
   logic        hit_h_ff, hit_h_in, hit_v_ff, hit_v_in;
   logic [DIST_W-1:0] dist_h_ff, dist_h_in, dist_v_ff, dist_v_in;
   logic        inb_ff, inb_in;
   logic [49:0] acc_ff, acc_in;

   // shared multiplier: registered operands, registered product
   logic signed [25:0] mul_a_ff, mul_a_in;
   logic signed [32:0] mul_b_ff, mul_b_in;
   logic signed [58:0] prod_ff;

   // map and root unit
   logic          map_we, map_wdata, map_rdata, map_clearing;
   logic [AW-1:0] map_waddr, map_raddr;
   logic          sq_start, sq_done;
   logic [SQ_IN_W-1:0]   sq_value;
   logic [SQ_ROOT_W-1:0] sq_root;

   // walk datapath
   logic [DIM_W-1:0]   wx, wy;
   logic               inb_x, inb_y;
   logic [31:0]        tidx;
   logic [COORD_W-1:0] fl_prod;
   logic [COORD_W-1:0] at4, nt4;
   logic [COORD_W-1:0] dxv, dyv, ax, ay;
   logic               over;
   logic [50:0]        sq_sum;
   logic [DIST_W-1:0]  root_sat;
   logic [19:0]        d_lo, d_hi;
   logic [31:0]        widx;
   logic               w_ok, req_acc;

   assign req_tready = (state_ff == ST_IDLE) && !map_clearing;
   assign req_acc    = req_tvalid && req_tready;

   // cell write straight from the request
   assign w_ok  = ({4'b0, f_col} < DIM_W'(MAP_COLS)) && ({4'b0, f_row} < DIM_W'(MAP_ROWS));
   assign widx  = 32'(f_row) * 32'(MAP_COLS) + 32'(f_col);
   assign map_we    = req_acc && (req_tuser == OP_WRITE) && w_ok;
   assign map_waddr = widx[AW-1:0];
   assign map_wdata = f_wall;

   // map bounds in use
   assign wx = ({3'b0, map_width_ff} < DIM_W'(MAP_COLS)) ? {3'b0, map_width_ff}
                                                         : DIM_W'(MAP_COLS);
   assign wy = ({3'b0, map_height_ff} < DIM_W'(MAP_ROWS)) ? {3'b0, map_height_ff}
                                                          : DIM_W'(MAP_ROWS);
   assign inb_x = !cx_ff[COORD_W-1] &&
                  (cx_ff[COORD_W-2:TILE_SH] < (COORD_W-1-TILE_SH)'(wx));
   assign inb_y = !cy_ff[COORD_W-1] &&
                  (cy_ff[COORD_W-2:TILE_SH] < (COORD_W-1-TILE_SH)'(wy));
   assign tidx  = 32'(cy_ff[TILE_SH+DIM_W-1:TILE_SH]) * 32'(MAP_COLS)
                + 32'(cx_ff[TILE_SH+DIM_W-1:TILE_SH]);
   assign map_raddr = tidx[AW-1:0];

   // floor(prod / 2^16), sign extended
   assign fl_prod = {{(COORD_W-43){prod_ff[58]}}, prod_ff[58:16]};
   assign at4 = {{(COORD_W-34){at_ff[31]}}, at_ff, 2'b00};
   assign nt4 = {{(COORD_W-34){nt_ff[31]}}, nt_ff, 2'b00};

   // offset from player to the first line: above/left (+) or below/right (-)
   assign d_lo = walk_v_ff ? ({2'b00, px_ff[17:0]} + 20'd1)
                           : ({2'b00, py_ff[17:0]} + 20'd1);
   assign d_hi = walk_v_ff ? ({2'b00, px_ff[17:0]} - 20'h40000)
                           : ({2'b00, py_ff[17:0]} - 20'h40000);

   assign dxv  = cx_ff - {{(COORD_W-24){1'b0}}, px_ff};
   assign dyv  = cy_ff - {{(COORD_W-24){1'b0}}, py_ff};
   assign ax   = dxv[COORD_W-1] ? (COORD_W'(0) - dxv) : dxv;
   assign ay   = dyv[COORD_W-1] ? (COORD_W'(0) - dyv) : dyv;
   assign over = (|ax[COORD_W-1:DIST_W]) || (|ay[COORD_W-1:DIST_W]);

   assign sq_sum   = {1'b0, acc_ff} + {1'b0, prod_ff[49:0]};
   assign sq_value = {1'b0, sq_sum};
   assign root_sat = sq_root[SQ_ROOT_W-1] ? DIST_MAX : sq_root[DIST_W-1:0];

   always_comb begin
      state_in  = state_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      ang_in    = ang_ff;
      at_in     = at_ff;
      nt_in     = nt_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      step_in   = step_ff;
      walk_v_in = walk_v_ff;
      hit_h_in  = hit_h_ff;
      hit_v_in  = hit_v_ff;
      dist_h_in = dist_h_ff;
      dist_v_in = dist_v_ff;
      inb_in    = inb_ff;
      acc_in    = acc_ff;
      mul_a_in  = mul_a_ff;
      mul_b_in  = mul_b_ff;
      sq_start  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_tuser == OP_CAST) begin
               px_in     = f_px;
               py_in     = f_py;
               ang_in    = f_ang;
               at_in     = f_at;
               nt_in     = f_nt;
               walk_v_in = 1'b0;
               hit_h_in  = 1'b0;
               hit_v_in  = 1'b0;
               dist_h_in = '0;
               dist_v_in = '0;
               state_in  = ST_SETUP;
            end
         end
         ST_SETUP: begin
            step_in  = '0;
            state_in = ST_MUL;
            if (!walk_v_ff) begin
               mul_b_in = {at_ff[31], at_ff};
               if (ang_ff > ANG_HALF) begin
                  // facing up: first line just above the player tile
                  cy_in    = {{(COORD_W-24){1'b0}}, py_ff[23:18], 18'b0} - COORD_W'(1);
                  mul_a_in = {{6{d_lo[19]}}, d_lo};
                  sx_in    = at4;
                  sy_in    = COORD_W'(0) - TILE;
               end else if (ang_ff < ANG_HALF && ang_ff != 16'd0) begin
                  cy_in    = {{(COORD_W-24){1'b0}}, py_ff[23:18], 18'b0} + TILE;
                  mul_a_in = {{6{d_hi[19]}}, d_hi};
                  sx_in    = COORD_W'(0) - at4;
                  sy_in    = TILE;
               end else begin
                  // parallel to horizontal lines
                  walk_v_in = 1'b1;
                  state_in  = ST_SETUP;
               end
            end else begin
               mul_b_in = {nt_ff[31], nt_ff};
               if (ang_ff > ANG_QUARTER && ang_ff < ANG_3QUARTER) begin
                  cx_in    = {{(COORD_W-24){1'b0}}, px_ff[23:18], 18'b0} - COORD_W'(1);
                  mul_a_in = {{6{d_lo[19]}}, d_lo};
                  sx_in    = COORD_W'(0) - TILE;
                  sy_in    = nt4;
               end else if (ang_ff < ANG_QUARTER || ang_ff > ANG_3QUARTER) begin
                  cx_in    = {{(COORD_W-24){1'b0}}, px_ff[23:18], 18'b0} + TILE;
                  mul_a_in = {{6{d_hi[19]}}, d_hi};
                  sx_in    = TILE;
                  sy_in    = COORD_W'(0) - nt4;
               end else begin
                  // parallel to vertical lines
                  state_in = ST_OUT;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_POS;
         end
         ST_POS: begin
            if (!walk_v_ff) begin
               cx_in = fl_prod + {{(COORD_W-24){1'b0}}, px_ff};
            end else begin
               cy_in = fl_prod + {{(COORD_W-24){1'b0}}, py_ff};
            end
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            inb_in   = inb_x && inb_y;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (inb_ff && map_rdata) begin
               if (!walk_v_ff) begin
                  hit_h_in = 1'b1;
               end else begin
                  hit_v_in = 1'b1;
               end
               state_in = ST_DIST;
            end else begin
               cx_in   = cx_ff + sx_ff;
               cy_in   = cy_ff + sy_ff;
               step_in = step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(MAX_STEPS - 1)) begin
                  walk_v_in = 1'b1;
                  state_in  = walk_v_ff ? ST_OUT : ST_SETUP;
               end else begin
                  state_in = ST_ADDR;
               end
            end
         end
         ST_DIST: begin
            if (over) begin
               if (!walk_v_ff) begin
                  dist_h_in = DIST_MAX;
               end else begin
                  dist_v_in = DIST_MAX;
               end
               walk_v_in = 1'b1;
               state_in  = walk_v_ff ? ST_OUT : ST_SETUP;
            end else begin
               mul_a_in = {1'b0, ax[DIST_W-1:0]};
               mul_b_in = {8'b0, ax[DIST_W-1:0]};
               state_in = ST_SQ_X;
            end
         end
         ST_SQ_X: begin
            mul_a_in = {1'b0, ay[DIST_W-1:0]};
            mul_b_in = {8'b0, ay[DIST_W-1:0]};
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            acc_in   = prod_ff[49:0];
            state_in = ST_SQ_SUM;
         end
         ST_SQ_SUM: begin
            sq_start = 1'b1;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (sq_done) begin
               if (!walk_v_ff) begin
                  dist_h_in = root_sat;
               end else begin
                  dist_v_in = root_sat;
               end
               walk_v_in = 1'b1;
               state_in  = walk_v_ff ? ST_OUT : ST_SETUP;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         map_width_ff  <= 7'd64;
         map_height_ff <= 7'd64;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_MAP_WIDTH:  map_width_ff  <= csr_wdata;
               CSR_MAP_HEIGHT: map_height_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      px_ff     <= px_in;
      py_ff     <= py_in;
      ang_ff    <= ang_in;
      at_ff     <= at_in;
      nt_ff     <= nt_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      step_ff   <= step_in;
      walk_v_ff <= walk_v_in;
      hit_h_ff  <= hit_h_in;
      hit_v_ff  <= hit_v_in;
      dist_h_ff <= dist_h_in;
      dist_v_ff <= dist_v_in;
      inb_ff    <= inb_in;
      acc_ff    <= acc_in;
      mul_a_ff  <= mul_a_in;
      mul_b_ff  <= mul_b_in;
      prod_ff   <= mul_a_ff * mul_b_ff;
   end

   grwd_map #(
      .MAP_COLS (MAP_COLS),
      .MAP_ROWS (MAP_ROWS),
      .AW       (AW)
   ) u_map (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (map_we),
      .wr_addr  (map_waddr),
      .wr_data  (map_wdata),
      .rd_addr  (map_raddr),
      .rd_data  (map_rdata),
      .clearing (map_clearing)
   );

   grwd_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .value (sq_value),
      .done  (sq_done),
      .root  (sq_root)
   );

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {4'b0, dist_v_ff, hit_v_ff, dist_h_ff, hit_h_ff};

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for grid_ray_wall_distance: map writes and ray casts
// are predicted by a local wall-map model and compared on the rsp channel.
// Depends on grwd_pkg and the grid_ray_wall_distance RTL.
`timescale 1ns / 1ps
module tb;
   import grwd_pkg::*;

   // one request transaction as the driver sees it
   typedef struct packed {
      logic        op;
      logic [5:0]  col;
      logic [5:0]  row;
      logic        wall;
      logic [23:0] px;
      logic [23:0] py;
      logic [15:0] ang;
      logic [31:0] itan;
      logic [31:0] ntan;
   } ray_req_type;

   // one cast result, laid out as on rsp_tdata (hit_h in bit 0)
   typedef struct packed {
      logic [24:0] dist_v;
      logic        hit_v;
      logic [24:0] dist_h;
      logic        hit_h;
   } ray_hit_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [55:0]  rsp_tdata;
   logic         csr_we = 1'b0;
   logic         csr_addr = 1'b0;
   logic [6:0]   csr_wdata = '0;

   grid_ray_wall_distance uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------- predictor state ----------------
   bit          tile_wall [64*64];
   logic [6:0]  cols_used = 7'd64;
   logic [6:0]  rows_used = 7'd64;

   ray_req_type pending_reqs[$];  // filled by the stimulus, drained by driver
   ray_hit_type expected_hits[$]; // predicted cast results, oldest first
   int          errors = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   bit          recv_hold = 1'b0;  // long receiver hold-off

   // Q.18 x Q16.16 product, floored to Q.18
   function automatic longint mul_floor(longint a, longint t);
      longint p;
      p = a * t;
      return p >>> 16;
   endfunction

   function automatic longint tile_idx(longint c);
      return c >>> 18;
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // one grid walk; returns hit and sets the saturated distance
   function automatic bit grid_walk(longint x, longint y, longint dx, longint dy,
                                    longint px, longint py, output logic [24:0] d);
      longint w, h, mx, my, ax, ay;
      longint unsigned dd;
      w = (cols_used < 64) ? cols_used : 64;
      h = (rows_used < 64) ? rows_used : 64;
      d = '0;
      for (int s = 0; s < 128; s++) begin
         mx = tile_idx(x);
         my = tile_idx(y);
         if (mx >= 0 && my >= 0 && mx < w && my < h && tile_wall[my*64 + mx]) begin
            ax = (x >= px) ? x - px : px - x;
            ay = (y >= py) ? y - py : py - y;
            dd = int_sqrt(ax*ax + ay*ay);
            d = (dd > 64'd33554431) ? DIST_MAX : dd[24:0];
            return 1'b1;
         end
         x += dx;
         y += dy;
      end
      return 1'b0;
   endfunction

   // apply one accepted transaction to the model
   task automatic predict_ray(ray_req_type r);
      ray_hit_type e;
      longint px, py, at, nt, x, y, base;
      logic [24:0] d;
      if (r.op == OP_WRITE) begin
         tile_wall[r.row*64 + r.col] = r.wall;
         return;
      end
      e = '0;
      px = r.px;
      py = r.py;
      at = longint'(signed'(r.itan));
      nt = longint'(signed'(r.ntan));
      base = (py >> 18) << 18;
      if (r.ang > ANG_HALF) begin
         y = base - 1;
         x = mul_floor(py - y, at) + px;
         e.hit_h = grid_walk(x, y, 4*at, -(64'sd1 << 18), px, py, d);
         e.dist_h = d;
      end else if (r.ang < ANG_HALF && r.ang != 0) begin
         y = base + (64'sd1 << 18);
         x = mul_floor(py - y, at) + px;
         e.hit_h = grid_walk(x, y, -4*at, 64'sd1 << 18, px, py, d);
         e.dist_h = d;
      end
      base = (px >> 18) << 18;
      if (r.ang > ANG_QUARTER && r.ang < ANG_3QUARTER) begin
         x = base - 1;
         y = mul_floor(px - x, nt) + py;
         e.hit_v = grid_walk(x, y, -(64'sd1 << 18), 4*nt, px, py, d);
         e.dist_v = d;
      end else if (r.ang < ANG_QUARTER || r.ang > ANG_3QUARTER) begin
         x = base + (64'sd1 << 18);
         y = mul_floor(px - x, nt) + py;
         e.hit_v = grid_walk(x, y, 64'sd1 << 18, -4*nt, px, py, d);
         e.dist_v = d;
      end
      expected_hits.push_back(e);
   endtask

   // ---------------- driver ----------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_ray(pending_reqs.pop_front());
         // offer the head item unless idling; keep a live offer in place
         if ((req_tvalid && !req_tready)) begin
            req_tvalid <= 1'b1;
         end else if (pending_reqs.size() > 0 &&
                      $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {3'b0, pending_reqs[0].ntan, pending_reqs[0].itan,
                           pending_reqs[0].ang, pending_reqs[0].py,
                           pending_reqs[0].px, pending_reqs[0].wall,
                           pending_reqs[0].row, pending_reqs[0].col};
            req_tuser  <= pending_reqs[0].op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      ray_hit_type got, e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[51:0];
            if (expected_hits.size() == 0) begin
               $display("%0t: unexpected result transaction %h", $realtime, got);
               errors++;
            end else begin
               e = expected_hits.pop_front();
               if (got.hit_h !== e.hit_h || got.dist_h !== e.dist_h) begin
                  $display("%0t: horizontal walk expected hit=%0d dist=%0d, got hit=%0d dist=%0d",
                           $realtime, e.hit_h, e.dist_h, got.hit_h, got.dist_h);
                  errors++;
               end
               if (got.hit_v !== e.hit_v || got.dist_v !== e.dist_v) begin
                  $display("%0t: vertical walk expected hit=%0d dist=%0d, got hit=%0d dist=%0d",
                           $realtime, e.hit_v, e.dist_v, got.hit_v, got.dist_v);
                  errors++;
               end
            end
         end
         rsp_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------- stimulus helpers ----------------
   function automatic ray_req_type map_write(int c, int r, bit w);
      ray_req_type q;
      q = '0;
      q.op = OP_WRITE;
      q.col = 6'(c);
      q.row = 6'(r);
      q.wall = w;
      return q;
   endfunction

   // cast with tangents roughly consistent with the angle
   function automatic ray_req_type cast_ray(logic [23:0] px, logic [23:0] py, logic [15:0] a);
      ray_req_type q;
      real th, tn;
      q = '0;
      q.op = OP_CAST;
      q.px = px;
      q.py = py;
      q.ang = a;
      q.col = 6'($urandom);
      q.row = 6'($urandom);
      q.wall = 1'($urandom);
      th = a * 3.14159265358979 / 32768.0;
      tn = $sin(th) / (($cos(th) == 0.0) ? 1e-9 : $cos(th));
      if (tn > 30000.0) tn = 30000.0;
      if (tn < -30000.0) tn = -30000.0;
      q.ntan = $rtoi(-tn * 65536.0);
      q.itan = (tn == 0.0) ? 32'sh7fffffff : ((-1.0/tn > 30000.0) ? 32'sh7fffffff :
               (-1.0/tn < -30000.0) ? 32'sh80000001 : $rtoi(-65536.0 / tn));
      return q;
   endfunction

   function automatic ray_req_type random_cast(int w, int h);
      ray_req_type q;
      logic [23:0] px, py;
      px = 24'(($urandom_range(w > 0 ? w - 1 : 0) << 18) | $urandom_range(18'h3ffff));
      py = 24'(($urandom_range(h > 0 ? h - 1 : 0) << 18) | $urandom_range(18'h3ffff));
      q = cast_ray(px, py, 16'($urandom));
      if ($urandom_range(9) == 0) begin
         q.itan = $urandom;  // raw tangents and positions: every bit, saturation
         q.ntan = $urandom;
         q.px = 24'($urandom);
         q.py = 24'($urandom);
      end
      return q;
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_tvalid || expected_hits.size() > 0)
         @(posedge clock);
      // a trailing write might still be in flight
      repeat (700) @(posedge clock);
   endtask

   task automatic set_size(logic [6:0] w, logic [6:0] h);
      @(posedge clock);
      csr_we <= 1'b1; csr_addr <= CSR_MAP_WIDTH; csr_wdata <= w;
      @(posedge clock);
      csr_addr <= CSR_MAP_HEIGHT; csr_wdata <= h;
      @(posedge clock);
      csr_we <= 1'b0;
      cols_used = w;
      rows_used = h;
   endtask

   task automatic random_phase(int n, int w, int h);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(3) == 0)
            pending_reqs.push_back(map_write($urandom, $urandom, $urandom_range(3) != 0));
         else
            pending_reqs.push_back(random_cast(w, h));
      end
   endtask

   // ---------------- main sequence ----------------
   initial begin
      int ww, hh;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: border walls, corner cells, parallel rays, far and near
      for (int k = 0; k < 64; k += 63) begin
         pending_reqs.push_back(map_write(k, 10, 1));
         pending_reqs.push_back(map_write(10, k, 1));
      end
      pending_reqs.push_back(map_write(20, 20, 1));
      pending_reqs.push_back(map_write(20, 20, 0));
      pending_reqs.push_back(cast_ray(24'h0a2000, 24'h0a2000, 16'd0));
      pending_reqs.push_back(cast_ray(24'h0a2000, 24'h0a2000, 16'd16384));
      pending_reqs.push_back(cast_ray(24'h0a2000, 24'h0a2000, 16'd32768));
      pending_reqs.push_back(cast_ray(24'h0a2000, 24'h0a2000, 16'd49152));
      pending_reqs.push_back(cast_ray(24'h0a2000, 24'h0a2000, 16'd65535));
      pending_reqs.push_back(cast_ray(24'h000000, 24'h000000, 16'd8192));
      pending_reqs.push_back(cast_ray(24'hffffff, 24'hffffff, 16'd40000));
      pending_reqs.push_back(cast_ray(24'h000000, 24'hffffff, 16'd1));
      begin
         ray_req_type q;
         q = cast_ray(24'h400000, 24'h400000, 16'd20000);
         q.itan = 32'sh7fffffff; q.ntan = 32'sh80000000;
         pending_reqs.push_back(q);
      end
      wait_drained();

      // sender idles 25%, receiver 81%
      send_idle_pct = 25; recv_idle_pct = 81;
      random_phase(250, 64, 64);
      // receiver holds off long enough for the block to stall its input
      recv_hold = 1'b1;
      repeat (3000) @(posedge clock);
      recv_hold = 1'b0;
      wait_drained();

      // small map and zero-size extremes, sender idles 81%, each size set once drained
      set_size(7'd8, 7'd5);
      send_idle_pct = 81; recv_idle_pct = 25;
      random_phase(150, 8, 5);
      wait_drained();
      set_size(7'd0, 7'd64);
      random_phase(30, 64, 64);
      wait_drained();
      set_size(7'd127, 7'd1);
      random_phase(50, 64, 1);
      wait_drained();

      send_idle_pct = 0; recv_idle_pct = 0;
      set_size(7'd64, 7'd64);
      // dense map so most walks hit
      for (int i = 0; i < 120; i++)
         pending_reqs.push_back(map_write($urandom, $urandom, 1));
      random_phase(250, 64, 64);
      wait_drained();

      if (errors == 0) begin
         $display("PASS grid_ray_wall_distance");
      end else begin
         $display("FAIL grid_ray_wall_distance");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("FAIL grid_ray_wall_distance");
      $finish;
   end

endmodule

// ----- sim.f -----
design/grwd_pkg.sv
design/grwd_map.sv
design/grwd_sqrt.sv
design/grid_ray_wall_distance.sv
verif/tb.sv
